>>> src/ssz_pkg.sv
// shared types and constants of the sphere splat depth-buffered renderer
package ssz_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_FOLD  = 2'd1,
      OP_DRAW  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // register indexes of the control port
   typedef enum logic [1:0] {
      REG_ROWS   = 2'd0,
      REG_COLS   = 2'd1,
      REG_RADIUS = 2'd2
   } reg_type;

   // top level sequencer
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TABLE,
      ST_WALK,
      ST_READ_ADDR,
      ST_READ_MEM,
      ST_READ_OUT
   } state_type;

   // shade table builder
   typedef enum logic [1:0] {
      TAB_IDLE,
      TAB_SETUP,
      TAB_DIV,
      TAB_WRITE
   } tab_state_type;

   localparam int DEPTH_W = 18;
   localparam int COLOR_W = 24;
   localparam int Q_W     = 9;
   localparam int TAB_W   = 2 * Q_W;

   localparam logic signed [DEPTH_W-1:0] DEPTH_EMPTY = 18'sh20000;
   localparam logic [Q_W-1:0] Q_ONE          = 9'd256;
   localparam logic [Q_W-1:0] Q_THREE_TENTHS = 9'd77;
   localparam logic [7:0]     Q_SEVEN_TENTHS = 8'd179;
   localparam logic [7:0]     Q_SAT_LIMIT    = 8'd180;
   localparam logic [3:0]     DIV_TOP_BIT    = 4'd8;

endpackage

>>> src/ssz_ram.sv
// generic simple dual port ram with registered read
module ssz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ssz_shade_tab.sv
// builds the per-bulge shade and depth intensity table for one draw
module ssz_shade_tab #(
   parameter int KW = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [KW-1:0]                       radius,
   input  logic signed [15:0]                  pos_depth,
   input  logic signed [ssz_pkg::DEPTH_W-1:0]  range_low,
   input  logic signed [ssz_pkg::DEPTH_W-1:0]  range_high,
   input  logic                                range_seen,
   output logic                                tab_we,
   output logic [KW-1:0]                       tab_waddr,
   output logic [ssz_pkg::TAB_W-1:0]           tab_wdata,
   output logic                                done
);

   ssz_pkg::tab_state_type phase_ff, phase_in;
   logic [KW-1:0]   dz_ff, dz_in;
   logic [3:0]      iter_ff, iter_in;
   logic [24:0]     inum_ff, inum_in;
   logic [16:0]     iden_ff, iden_in;
   logic            isat_ff, isat_in;
   logic [8:0]      iq_ff, iq_in;
   logic [KW+8:0]   snum_ff, snum_in;
   logic [8:0]      sq_ff, sq_in;

   logic signed [17:0] z2;
   logic signed [18:0] z_rel, span;
   logic [16:0]        dpos;
   logic [24:0]        num, lim;
   logic [25:0]        icmp;
   logic [KW+8:0]      scmp;
   logic [8:0]         inten;

   // per-bulge setup values
   always_comb begin
      z2    = 18'(pos_depth) + $signed({{(18-KW){1'b0}}, dz_ff});
      z_rel = 19'(z2) - 19'(range_low);
      span  = 19'(range_high) - 19'(range_low);
      dpos  = z_rel[18] ? 17'd0 : z_rel[16:0];
      num   = 25'(dpos) * 25'(ssz_pkg::Q_SEVEN_TENTHS);
      lim   = 25'(span[16:0]) * 25'(ssz_pkg::Q_SAT_LIMIT);
      icmp  = 26'(iden_ff) << iter_ff;
      scmp  = (KW+9)'(radius) << iter_ff;
      inten = isat_ff ? ssz_pkg::Q_ONE : ssz_pkg::Q_THREE_TENTHS + iq_ff;
   end

   // sequencer for setup, restoring division and table write
   always_comb begin
      phase_in = phase_ff;
      dz_in    = dz_ff;
      iter_in  = iter_ff;
      inum_in  = inum_ff;
      iden_in  = iden_ff;
      isat_in  = isat_ff;
      iq_in    = iq_ff;
      snum_in  = snum_ff;
      sq_in    = sq_ff;
      tab_we   = 1'b0;
      done     = 1'b0;
      case (phase_ff)
         ssz_pkg::TAB_IDLE: begin
            if (start) begin
               dz_in    = '0;
               phase_in = ssz_pkg::TAB_SETUP;
            end
         end
         ssz_pkg::TAB_SETUP: begin
            inum_in  = num;
            iden_in  = span[16:0];
            isat_in  = !range_seen || span[18] || (span == 19'sd0) || (num >= lim);
            snum_in  = {1'b0, dz_ff, 8'd0};
            iq_in    = '0;
            sq_in    = '0;
            iter_in  = ssz_pkg::DIV_TOP_BIT;
            phase_in = ssz_pkg::TAB_DIV;
         end
         ssz_pkg::TAB_DIV: begin
            if (26'(inum_ff) >= icmp) begin
               inum_in = 25'(26'(inum_ff) - icmp);
               iq_in   = iq_ff | (9'd1 << iter_ff);
            end
            if (snum_ff >= scmp) begin
               snum_in = snum_ff - scmp;
               sq_in   = sq_ff | (9'd1 << iter_ff);
            end
            if (iter_ff == 4'd0) begin
               phase_in = ssz_pkg::TAB_WRITE;
            end else begin
               iter_in = iter_ff - 4'd1;
            end
         end
         ssz_pkg::TAB_WRITE: begin
            tab_we = 1'b1;
            if (dz_ff == radius) begin
               done     = 1'b1;
               phase_in = ssz_pkg::TAB_IDLE;
            end else begin
               dz_in    = dz_ff + KW'(1);
               phase_in = ssz_pkg::TAB_SETUP;
            end
         end
         default: phase_in = ssz_pkg::TAB_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ssz_pkg::TAB_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      dz_ff   <= dz_in;
      iter_ff <= iter_in;
      inum_ff <= inum_in;
      iden_ff <= iden_in;
      isat_ff <= isat_in;
      iq_ff   <= iq_in;
      snum_ff <= snum_in;
      sq_ff   <= sq_in;
   end

   assign tab_waddr = dz_ff;
   assign tab_wdata = {sq_ff, inten};

endmodule

>>> src/ssz_raster.sv
// disk offset walk, bulge square root pipeline, depth test and shading
module ssz_raster #(
   parameter int KW  = 4,
   parameter int RW  = 8,
   parameter int CW  = 8,
   parameter int RIW = 7,
   parameter int CIW = 7,
   parameter int AW  = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [KW-1:0]                       radius,
   input  logic signed [15:0]                  pos_row,
   input  logic signed [15:0]                  pos_col,
   input  logic signed [15:0]                  pos_depth,
   input  logic [7:0]                          color_first,
   input  logic [7:0]                          color_second,
   input  logic [7:0]                          color_third,
   input  logic [RW-1:0]                       rows_eff,
   input  logic [CW-1:0]                       cols_eff,
   output logic [AW-1:0]                       depth_raddr,
   input  logic [ssz_pkg::DEPTH_W-1:0]         depth_rdata,
   output logic [KW-1:0]                       tab_raddr,
   input  logic [ssz_pkg::TAB_W-1:0]           tab_rdata,
   output logic                                depth_we,
   output logic [AW-1:0]                       depth_waddr,
   output logic [ssz_pkg::DEPTH_W-1:0]         depth_wdata,
   output logic                                color_we,
   output logic [AW-1:0]                       color_waddr,
   output logic [ssz_pkg::COLOR_W-1:0]         color_wdata,
   output logic                                done
);

   // offset walk
   logic               walk_ff;
   logic signed [KW:0] dx_ff, dy_ff;
   logic signed [KW:0] r_s;
   logic [2*KW-1:0]    r_sq;
   logic signed [2*KW+1:0] rr_s, dx2, dy2, rem_s;
   logic signed [16:0] x2, y2;
   logic               s0_v;

   assign r_s  = $signed({1'b0, radius});
   assign r_sq = (2*KW)'(radius) * (2*KW)'(radius);

   always_comb begin
      rr_s  = $signed({2'b00, r_sq});
      dx2   = (2*KW+2)'(dx_ff) * (2*KW+2)'(dx_ff);
      dy2   = (2*KW+2)'(dy_ff) * (2*KW+2)'(dy_ff);
      rem_s = rr_s - dx2 - dy2;
      x2    = 17'(pos_row) + 17'(dx_ff);
      y2    = 17'(pos_col) + 17'(dy_ff);
      s0_v  = walk_ff && !rem_s[2*KW+1] && (rem_s != '0)
              && !x2[16] && (x2[15:0] < 16'(rows_eff))
              && !y2[16] && (y2[15:0] < 16'(cols_eff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0;
      end else if (start) begin
         walk_ff <= 1'b1;
         dx_ff   <= -r_s;
         dy_ff   <= -r_s;
      end else if (walk_ff) begin
         if (dy_ff == r_s) begin
            dy_ff <= -r_s;
            if (dx_ff == r_s) begin
               walk_ff <= 1'b0;
            end else begin
               dx_ff <= dx_ff + (KW+1)'(1);
            end
         end else begin
            dy_ff <= dy_ff + (KW+1)'(1);
         end
      end
   end

   // offset registers
   logic             p1_v_ff;
   logic [2*KW-1:0]  p1_rem_ff;
   logic [RIW-1:0]   p1_x_ff;
   logic [CIW-1:0]   p1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= s0_v;
      end
      p1_rem_ff <= rem_s[2*KW-1:0];
      p1_x_ff   <= x2[RIW-1:0];
      p1_y_ff   <= y2[CIW-1:0];
   end

   // pixel address
   logic [RIW+CW-1:0] row_base;
   logic [AW-1:0]     p1_addr;

   assign row_base = (RIW+CW)'(p1_x_ff) * (RIW+CW)'(cols_eff);
   assign p1_addr  = AW'(row_base) + AW'(p1_y_ff);

   // square root stages, one result bit each
   logic [KW:0]      s_v_ff;
   logic [2*KW-1:0]  s_rem_ff  [KW+1];
   logic [AW-1:0]    s_addr_ff [KW+1];
   logic [KW-1:0]    s_res_ff  [KW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff <= '0;
      end else begin
         s_v_ff <= {s_v_ff[KW-1:0], p1_v_ff};
      end
      s_rem_ff[0]  <= p1_rem_ff;
      s_addr_ff[0] <= p1_addr;
      s_res_ff[0]  <= '0;
   end

   for (genvar k = 0; k < KW; k++) begin : g_sqrt
      localparam int B = KW - 1 - k;
      logic [KW-1:0]   trial;
      logic [2*KW-1:0] trial_sq;

      assign trial    = s_res_ff[k] | (KW'(1) << B);
      assign trial_sq = (2*KW)'(trial) * (2*KW)'(trial);

      always_ff @(posedge clock) begin
         s_rem_ff[k+1]  <= s_rem_ff[k];
         s_addr_ff[k+1] <= s_addr_ff[k];
         s_res_ff[k+1]  <= (trial_sq <= s_rem_ff[k]) ? trial : s_res_ff[k];
      end
   end

   // memory read stage
   logic           m_v_ff;
   logic [AW-1:0]  m_addr_ff;
   logic [KW-1:0]  m_dz_ff;

   assign depth_raddr = s_addr_ff[KW];
   assign tab_raddr   = s_res_ff[KW];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else begin
         m_v_ff <= s_v_ff[KW];
      end
      m_addr_ff <= s_addr_ff[KW];
      m_dz_ff   <= s_res_ff[KW];
   end

   // depth test and depth write
   logic signed [17:0] z2;
   logic               hit;

   assign z2  = 18'(pos_depth) + $signed({{(18-KW){1'b0}}, m_dz_ff});
   assign hit = m_v_ff && ($signed(depth_rdata) < z2);

   assign depth_we    = hit;
   assign depth_waddr = m_addr_ff;
   assign depth_wdata = z2;

   // shade times intensity
   logic                 c_v_ff;
   logic [AW-1:0]        c_addr_ff;
   logic [2*ssz_pkg::Q_W-1:0] c_ps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= hit;
      end
      c_addr_ff <= m_addr_ff;
      c_ps_ff   <= (2*ssz_pkg::Q_W)'(tab_rdata[ssz_pkg::TAB_W-1:ssz_pkg::Q_W])
                 * (2*ssz_pkg::Q_W)'(tab_rdata[ssz_pkg::Q_W-1:0]);
   end

   // channel scaling with saturation
   logic [25:0] prod_b, prod_g, prod_r;
   logic [7:0]  ch_b, ch_g, ch_r;

   always_comb begin
      prod_b = 26'(color_third) * 26'(c_ps_ff);
      prod_g = 26'(color_first) * 26'(c_ps_ff);
      prod_r = 26'(color_second) * 26'(c_ps_ff);
      ch_b   = (|prod_b[25:24]) ? 8'hFF : prod_b[23:16];
      ch_g   = (|prod_g[25:24]) ? 8'hFF : prod_g[23:16];
      ch_r   = (|prod_r[25:24]) ? 8'hFF : prod_r[23:16];
   end

   assign color_we    = c_v_ff;
   assign color_waddr = c_addr_ff;
   assign color_wdata = {ch_r, ch_g, ch_b};

   assign done = !walk_ff && !p1_v_ff && !(|s_v_ff) && !m_v_ff && !c_v_ff;

endmodule

>>> src/sphere_splat_zbuffer_renderer.sv
// top level of the sphere splat depth-buffered renderer
//
// channel   direction  handshake             contents
// req       in         req_valid/req_ready   op, point position, depth, three colors
// rsp       out        rsp_valid/rsp_ready   blue, green, red of one pixel (read only)
// csr       in/out     apb, pready tied high image rows, image columns, ball radius
//
// one request at a time. a fold only updates the depth range; a read steps
// through ST_READ_ADDR, ST_READ_MEM and ST_READ_OUT; a start frame sweeps the
// depth store, one entry a cycle. a draw first builds the shade table in the
// iterative divider, then runs the offset walk over (2r+1)^2 offsets, one depth
// read-modify-write a cycle, then the pipeline drains. after reset both stores
// are swept before the first request is taken. a pending response holds only a
// later read.
module sphere_splat_zbuffer_renderer #(
   parameter int MAX_ROWS   = 128,
   parameter int MAX_COLS   = 128,
   parameter int MAX_RADIUS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_pos_row,
   input  logic signed [15:0] req_pos_col,
   input  logic signed [15:0] req_pos_depth,
   input  logic [7:0]         req_color_first,
   input  logic [7:0]         req_color_second,
   input  logic [7:0]         req_color_third,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_pixel_blue,
   output logic [7:0]         rsp_pixel_green,
   output logic [7:0]         rsp_pixel_red,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RIW   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
   localparam int KW    = $clog2(MAX_RADIUS + 1);

   // control registers
   logic [7:0] image_rows_ff, image_cols_ff;
   logic [3:0] ball_radius_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff  <= 8'd128;
         image_cols_ff  <= 8'd128;
         ball_radius_ff <= 4'd1;
      end else if (csr_wr) begin
         case (ssz_pkg::reg_type'(paddr[3:2]))
            ssz_pkg::REG_ROWS:   image_rows_ff  <= pwdata[7:0];
            ssz_pkg::REG_COLS:   image_cols_ff  <= pwdata[7:0];
            ssz_pkg::REG_RADIUS: ball_radius_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ssz_pkg::reg_type'(paddr[3:2]))
         ssz_pkg::REG_ROWS:   prdata = {24'd0, image_rows_ff};
         ssz_pkg::REG_COLS:   prdata = {24'd0, image_cols_ff};
         ssz_pkg::REG_RADIUS: prdata = {28'd0, ball_radius_ff};
         default:             prdata = '0;
      endcase
   end

   // effective image size and radius
   logic [RW-1:0] rows_eff;
   logic [CW-1:0] cols_eff;
   logic [KW-1:0] r_eff;

   always_comb begin
      rows_eff = (32'(image_rows_ff) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(image_rows_ff);
      cols_eff = (32'(image_cols_ff) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(image_cols_ff);
      if (ball_radius_ff == 4'd0) begin
         r_eff = KW'(1);
      end else if (32'(ball_radius_ff) > 32'(MAX_RADIUS)) begin
         r_eff = KW'(MAX_RADIUS);
      end else begin
         r_eff = KW'(ball_radius_ff);
      end
   end

   // request registers
   ssz_pkg::state_type state_ff, state_in;
   ssz_pkg::op_type    op_ff;
   logic signed [15:0] row_ff, col_ff, z_ff;
   logic [7:0]         c_first_ff, c_second_ff, c_third_ff;
   logic               req_acc;

   assign req_acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff       <= ssz_pkg::op_type'(req_op);
         row_ff      <= req_pos_row;
         col_ff      <= req_pos_col;
         z_ff        <= req_pos_depth;
         c_first_ff  <= req_color_first;
         c_second_ff <= req_color_second;
         c_third_ff  <= req_color_third;
      end
   end

   // depth range
   logic signed [ssz_pkg::DEPTH_W-1:0] range_low_ff, range_high_ff;
   logic signed [ssz_pkg::DEPTH_W-1:0] fold_lo, fold_hi;
   logic                               range_seen_ff;

   assign fold_lo = 18'(req_pos_depth) - $signed(18'(r_eff));
   assign fold_hi = 18'(req_pos_depth) + $signed(18'(r_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '0;
         range_seen_ff <= 1'b0;
      end else if (req_acc && (req_op == ssz_pkg::OP_START)) begin
         range_low_ff  <= '0;
         range_high_ff <= '0;
         range_seen_ff <= 1'b0;
      end else if (req_acc && (req_op == ssz_pkg::OP_FOLD)) begin
         range_seen_ff <= 1'b1;
         if (!range_seen_ff || (fold_lo < range_low_ff)) begin
            range_low_ff <= fold_lo;
         end
         if (!range_seen_ff || (fold_hi > range_high_ff)) begin
            range_high_ff <= fold_hi;
         end
      end
   end

   // memories
   logic                         depth_we, color_we, tab_we, color_re;
   logic [AW-1:0]                depth_waddr, color_waddr, depth_raddr, color_raddr;
   logic [ssz_pkg::DEPTH_W-1:0]  depth_wdata, depth_rdata;
   logic [ssz_pkg::COLOR_W-1:0]  color_wdata, color_rdata;
   logic [KW-1:0]                tab_waddr, tab_raddr;
   logic [ssz_pkg::TAB_W-1:0]    tab_wdata, tab_rdata;

   ssz_ram #(.WIDTH(ssz_pkg::DEPTH_W), .DEPTH(DEPTH)) u_depth_ram (
      .clock(clock), .we(depth_we), .waddr(depth_waddr), .wdata(depth_wdata),
      .re(1'b1), .raddr(depth_raddr), .rdata(depth_rdata)
   );

   ssz_ram #(.WIDTH(ssz_pkg::COLOR_W), .DEPTH(DEPTH)) u_color_ram (
      .clock(clock), .we(color_we), .waddr(color_waddr), .wdata(color_wdata),
      .re(color_re), .raddr(color_raddr), .rdata(color_rdata)
   );

   ssz_ram #(.WIDTH(ssz_pkg::TAB_W), .DEPTH(MAX_RADIUS + 1)) u_tab_ram (
      .clock(clock), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
      .re(1'b1), .raddr(tab_raddr), .rdata(tab_rdata)
   );

   // shade table builder
   logic tab_start, tab_done;

   ssz_shade_tab #(.KW(KW)) u_shade_tab (
      .clock(clock), .reset(reset), .start(tab_start), .radius(r_eff),
      .pos_depth(z_ff), .range_low(range_low_ff), .range_high(range_high_ff),
      .range_seen(range_seen_ff), .tab_we(tab_we), .tab_waddr(tab_waddr),
      .tab_wdata(tab_wdata), .done(tab_done)
   );

   // raster pipeline
   logic                        ras_start, ras_done;
   logic                        ras_depth_we, ras_color_we;
   logic [AW-1:0]               ras_depth_waddr, ras_color_waddr;
   logic [ssz_pkg::DEPTH_W-1:0] ras_depth_wdata;
   logic [ssz_pkg::COLOR_W-1:0] ras_color_wdata;

   ssz_raster #(
      .KW(KW), .RW(RW), .CW(CW), .RIW(RIW), .CIW(CIW), .AW(AW)
   ) u_raster (
      .clock(clock), .reset(reset), .start(ras_start), .radius(r_eff),
      .pos_row(row_ff), .pos_col(col_ff), .pos_depth(z_ff),
      .color_first(c_first_ff), .color_second(c_second_ff), .color_third(c_third_ff),
      .rows_eff(rows_eff), .cols_eff(cols_eff),
      .depth_raddr(depth_raddr), .depth_rdata(depth_rdata),
      .tab_raddr(tab_raddr), .tab_rdata(tab_rdata),
      .depth_we(ras_depth_we), .depth_waddr(ras_depth_waddr),
      .depth_wdata(ras_depth_wdata),
      .color_we(ras_color_we), .color_waddr(ras_color_waddr),
      .color_wdata(ras_color_wdata), .done(ras_done)
   );

   // clearing sweep
   logic [AW-1:0] clr_ff;
   logic          clear_color_ff;
   logic          clearing;

   assign clearing = (state_ff == ssz_pkg::ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff         <= '0;
         clear_color_ff <= 1'b1;
      end else if (clearing) begin
         clr_ff <= (clr_ff == AW'(DEPTH - 1)) ? '0 : clr_ff + AW'(1);
         if (clr_ff == AW'(DEPTH - 1)) begin
            clear_color_ff <= 1'b0;
         end
      end
   end

   assign depth_we    = clearing || ras_depth_we;
   assign depth_waddr = clearing ? clr_ff : ras_depth_waddr;
   assign depth_wdata = clearing ? ssz_pkg::DEPTH_EMPTY : ras_depth_wdata;
   assign color_we    = (clearing && clear_color_ff) || ras_color_we;
   assign color_waddr = clearing ? clr_ff : ras_color_waddr;
   assign color_wdata = clearing ? '0 : ras_color_wdata;

   // pixel read address
   logic [AW-1:0]     rd_addr_ff;
   logic              rd_in_ff;
   logic [RIW+CW-1:0] rd_base;

   assign rd_base = (RIW+CW)'(row_ff[RIW-1:0]) * (RIW+CW)'(cols_eff);

   always_ff @(posedge clock) begin
      if (state_ff == ssz_pkg::ST_READ_ADDR) begin
         rd_addr_ff <= AW'(rd_base) + AW'(col_ff[CIW-1:0]);
         rd_in_ff   <= !row_ff[15] && (row_ff[14:0] < 15'(rows_eff))
                       && !col_ff[15] && (col_ff[14:0] < 15'(cols_eff));
      end
   end

   assign color_raddr = rd_addr_ff;
   assign color_re    = (state_ff == ssz_pkg::ST_READ_MEM);

   // response register
   logic       rsp_valid_ff;
   logic [7:0] rsp_blue_ff, rsp_green_ff, rsp_red_ff;
   logic       rsp_load;

   assign rsp_load = (state_ff == ssz_pkg::ST_READ_OUT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_blue_ff  <= rd_in_ff ? color_rdata[7:0]   : 8'd0;
         rsp_green_ff <= rd_in_ff ? color_rdata[15:8]  : 8'd0;
         rsp_red_ff   <= rd_in_ff ? color_rdata[23:16] : 8'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_blue  = rsp_blue_ff;
   assign rsp_pixel_green = rsp_green_ff;
   assign rsp_pixel_red   = rsp_red_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      tab_start = 1'b0;
      ras_start = 1'b0;
      case (state_ff)
         ssz_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ssz_pkg::ST_IDLE;
            end
         end
         ssz_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (ssz_pkg::op_type'(req_op))
                  ssz_pkg::OP_START: state_in = ssz_pkg::ST_CLEAR;
                  ssz_pkg::OP_FOLD:  state_in = ssz_pkg::ST_IDLE;
                  ssz_pkg::OP_DRAW: begin
                     tab_start = 1'b1;
                     state_in  = ssz_pkg::ST_TABLE;
                  end
                  ssz_pkg::OP_READ:  state_in = ssz_pkg::ST_READ_ADDR;
                  default:           state_in = ssz_pkg::ST_IDLE;
               endcase
            end
         end
         ssz_pkg::ST_TABLE: begin
            if (tab_done) begin
               ras_start = 1'b1;
               state_in  = ssz_pkg::ST_WALK;
            end
         end
         ssz_pkg::ST_WALK: begin
            if (ras_done) begin
               state_in = ssz_pkg::ST_IDLE;
            end
         end
         ssz_pkg::ST_READ_ADDR: state_in = ssz_pkg::ST_READ_MEM;
         ssz_pkg::ST_READ_MEM:  state_in = ssz_pkg::ST_READ_OUT;
         ssz_pkg::ST_READ_OUT: begin
            if (rsp_load) begin
               state_in = ssz_pkg::ST_IDLE;
            end
         end
         default: state_in = ssz_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssz_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ssz_pkg::ST_READ_OUT)
      else $error("response raised outside read completion");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssz_pkg::ST_IDLE) |-> !depth_we && !color_we)
      else $error("store written while idle");

   a_tab_in_table: assert property (@(posedge clock) disable iff (reset)
      tab_we |-> (state_ff == ssz_pkg::ST_TABLE))
      else $error("shade table written outside table build");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_op != ssz_pkg::OP_FOLD)) |=> (state_ff != ssz_pkg::ST_IDLE))
      else $error("request did not start work");

endmodule

>>> bench/tb_top.sv
// self-checking bench for the sphere splat depth-buffered renderer
module tb_top;

   localparam int ROWS_MAX = 128;
   localparam int COLS_MAX = 128;
   localparam int RAD_MAX  = 15;
   localparam int STORE_N  = ROWS_MAX * COLS_MAX;
   localparam int SENTINEL = -131072;
   localparam int IDLE_WAIT = STORE_N + 1200;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = ssz_pkg::OP_READ;
   logic signed [15:0] req_pos_row = '0;
   logic signed [15:0] req_pos_col = '0;
   logic signed [15:0] req_pos_depth = '0;
   logic [7:0]         req_color_first = '0;
   logic [7:0]         req_color_second = '0;
   logic [7:0]         req_color_third = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_pixel_blue;
   logic [7:0]         rsp_pixel_green;
   logic [7:0]         rsp_pixel_red;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   sphere_splat_zbuffer_renderer DUT (.*);

   always #10 clock = ~clock;

   // renderer image state as the bench predicts it
   int        depth_img [STORE_N];
   pixel_type color_img [STORE_N];
   int        rng_low, rng_high;
   bit        rng_seen;
   int        rows_reg, cols_reg, radius_reg;
   pixel_type pixel_q [$];

   bit quiet = 1'b0;
   int errors = 0;
   int cycles = 0;
   int hold_ask = 0, hold_seen = 0, hold_cnt = 0, stall_cnt = 0;

   function automatic int radius_eff();
      int r = radius_reg;
      if (r > RAD_MAX) r = RAD_MAX;
      if (r < 1) r = 1;
      return r;
   endfunction

   function automatic int rows_eff();
      return (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
   endfunction

   function automatic int cols_eff();
      return (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
   endfunction

   function automatic int depth_intensity(int z2);
      longint span = longint'(rng_high) - rng_low;
      longint d = longint'(z2) - rng_low;
      longint v;
      if (!rng_seen || span <= 0) return 256;
      if (d < 0) d = 0;
      v = 77 + (d * 179) / span;
      return (v > 256) ? 256 : int'(v);
   endfunction

   function automatic logic [7:0] shade_channel(int c, int shade, int inten);
      longint v = (longint'(c) * shade * inten) >>> 16;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // update the predicted image for one accepted request
   function automatic void apply_request(ssz_pkg::op_type op, int row, int col, int z,
                                         int c0, int c1, int c2);
      int r, rw, cl, rem, dz, z2, x2, y2, addr, shade, inten;
      pixel_type px;
      r = radius_eff();
      rw = rows_eff();
      cl = cols_eff();
      case (op)
         ssz_pkg::OP_START: begin
            foreach (depth_img[i]) depth_img[i] = SENTINEL;
            rng_low = 0;
            rng_high = 0;
            rng_seen = 0;
         end
         ssz_pkg::OP_FOLD: begin
            if (!rng_seen) begin
               rng_low = z - r;
               rng_high = z + r;
               rng_seen = 1;
            end else begin
               if (z - r < rng_low) rng_low = z - r;
               if (z + r > rng_high) rng_high = z + r;
            end
         end
         ssz_pkg::OP_DRAW: begin
            for (int dx = -r; dx <= r; dx++) begin
               for (int dy = -r; dy <= r; dy++) begin
                  rem = r * r - dx * dx - dy * dy;
                  x2 = row + dx;
                  y2 = col + dy;
                  if (rem > 0 && x2 >= 0 && x2 < rw && y2 >= 0 && y2 < cl) begin
                     dz = 0;
                     while ((dz + 1) * (dz + 1) <= rem) dz++;
                     z2 = z + dz;
                     addr = x2 * cl + y2;
                     if (depth_img[addr] < z2) begin
                        depth_img[addr] = z2;
                        shade = (dz * 256) / r;
                        inten = depth_intensity(z2);
                        color_img[addr].blue = shade_channel(c2, shade, inten);
                        color_img[addr].green = shade_channel(c0, shade, inten);
                        color_img[addr].red = shade_channel(c1, shade, inten);
                     end
                  end
               end
            end
         end
         default: begin
            px = '0;
            if (row >= 0 && row < rw && col >= 0 && col < cl)
               px = color_img[row * cl + col];
            pixel_q = {pixel_q, px};
         end
      endcase
   endfunction

   // offer one request, with an occasional gap before it
   task automatic send_request(ssz_pkg::op_type op, int row, int col, int z,
                               int c0, int c1, int c2);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pos_row <= row[15:0];
      req_pos_col <= col[15:0];
      req_pos_depth <= z[15:0];
      req_color_first <= c0[7:0];
      req_color_second <= c1[7:0];
      req_color_third <= c2[7:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(op, $signed(row[15:0]), $signed(col[15:0]), $signed(z[15:0]),
                    c0 & 255, c1 & 255, c2 & 255);
   endtask

   // stop offering and wait for every pending pixel
   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
   endtask

   // drain, let a start frame or draw finish, then write one register
   task automatic write_reg(ssz_pkg::reg_type idx, int value);
      wait_results();
      repeat (IDLE_WAIT) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         ssz_pkg::REG_ROWS: rows_reg = value & 255;
         ssz_pkg::REG_COLS: cols_reg = value & 255;
         ssz_pkg::REG_RADIUS: radius_reg = value & 15;
         default: ;
      endcase
   endtask

   task automatic send_read(int row, int col);
      send_request(ssz_pkg::OP_READ, row, col, $urandom, $urandom, $urandom, $urandom);
   endtask

   // extremes and named special cases at reset settings
   task automatic test_directed();
      send_read(0, 0);
      send_request(ssz_pkg::OP_DRAW, 0, 0, 32767, 255, 255, 255);
      send_read(0, 0);
      send_read(0, 1);
      send_read(-1, 0);
      send_read(0, 128);
      send_read(-32768, 32767);
      send_read(32767, -32768);
      send_request(ssz_pkg::OP_FOLD, 3, 3, 100, 0, 0, 0);
      send_request(ssz_pkg::OP_FOLD, 3, 3, 200, 0, 0, 0);
      send_request(ssz_pkg::OP_DRAW, 5, 5, 0, 200, 100, 50);
      send_read(5, 5);
      send_request(ssz_pkg::OP_DRAW, 127, 127, 150, 17, 240, 129);
      send_read(127, 127);
      send_request(ssz_pkg::OP_DRAW, 127, 127, 150, 255, 255, 255);
      send_read(127, 127);
      send_request(ssz_pkg::OP_START, 0, 0, 0, 0, 0, 0);
      send_request(ssz_pkg::OP_DRAW, 5, 5, -32768, 1, 2, 3);
      send_read(5, 5);
      send_read(5, 6);
      send_request(ssz_pkg::OP_DRAW, 64, 64, 201, 255, 0, 128);
      send_read(64, 64);
      // write to an address past the register list is ignored
      write_reg(ssz_pkg::reg_type'(2'd3), 32'hFFFF_FFFF);
      send_read(64, 64);
   endtask

   // a frame: start, fold points, draw them, read back around them
   task automatic run_frame(int n_points, int n_reads);
      int prow [$], pcol [$], pz [$];
      int rw, cl, r, k;
      rw = rows_eff();
      cl = cols_eff();
      r = radius_eff();
      send_request(ssz_pkg::OP_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
      for (int i = 0; i < n_points; i++) begin
         prow = {prow, int'($urandom_range(0, (rw > 0 ? rw : 1) + 2 * r) - r)};
         pcol = {pcol, int'($urandom_range(0, (cl > 0 ? cl : 1) + 2 * r) - r)};
         pz = {pz, int'(($urandom_range(0, 3) == 0) ? $signed(16'($urandom))
                                                   : $urandom_range(0, 400) - 200)};
         if ($urandom_range(0, 4) != 0)
            send_request(ssz_pkg::OP_FOLD, prow[i], pcol[i], pz[i], 0, 0, 0);
      end
      for (int i = 0; i < n_points; i++) begin
         send_request(ssz_pkg::OP_DRAW, prow[i], pcol[i], pz[i],
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
         // a little noise between the draws
         if ($urandom_range(0, 5) == 0)
            send_request(ssz_pkg::op_type'($urandom_range(1, 3)), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      end
      for (int i = 0; i < n_reads; i++) begin
         k = $urandom_range(0, n_points - 1);
         if ($urandom_range(0, 7) == 0) send_read($urandom, $urandom);
         else send_read(prow[k] + $urandom_range(0, 2 * r) - r,
                        pcol[k] + $urandom_range(0, 2 * r) - r);
      end
   endtask

   // register settings sweep, two frames each
   task automatic test_frames();
      int set_rows [5] = '{128, 1, 255, 37, 128};
      int set_cols [5] = '{128, 1, 255, 90, 0};
      int set_rad  [5] = '{3, 15, 0, 7, 2};
      for (int p = 0; p < 5; p++) begin
         write_reg(ssz_pkg::REG_ROWS, set_rows[p]);
         write_reg(ssz_pkg::REG_COLS, set_cols[p]);
         write_reg(ssz_pkg::REG_RADIUS, set_rad[p]);
         run_frame((set_rad[p] == 15) ? 8 : 16, 26);
         if (p == 2) begin
            // pause until every pixel is back before the next frame
            wait_results();
         end
         run_frame((set_rad[p] == 15) ? 6 : 12, 20);
      end
   endtask

   // receiver holds off while reads keep coming, so the input stalls
   task automatic test_backpressure();
      write_reg(ssz_pkg::REG_ROWS, 128);
      write_reg(ssz_pkg::REG_COLS, 128);
      write_reg(ssz_pkg::REG_RADIUS, 4);
      run_frame(6, 4);
      hold_ask++;
      for (int i = 0; i < 20; i++) send_read($urandom_range(0, 127), $urandom_range(0, 127));
   endtask

   // no idling on either side in the last part
   task automatic test_no_idle();
      quiet = 1'b1;
      run_frame(8, 24);
   endtask

   // receiver ready with random stall bursts and one long hold
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_cnt <= 3000;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_cnt <= $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each returned pixel with the oldest prediction
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: expected no pixel, actual b=%0d g=%0d r=%0d", $time,
                     rsp_pixel_blue, rsp_pixel_green, rsp_pixel_red);
            errors++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_pixel_blue !== want.blue) begin
               $display("%0t: blue expected %0d actual %0d", $time, want.blue, rsp_pixel_blue);
               errors++;
            end
            if (rsp_pixel_green !== want.green) begin
               $display("%0t: green expected %0d actual %0d", $time, want.green,
                        rsp_pixel_green);
               errors++;
            end
            if (rsp_pixel_red !== want.red) begin
               $display("%0t: red expected %0d actual %0d", $time, want.red, rsp_pixel_red);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      foreach (depth_img[i]) begin
         depth_img[i] = SENTINEL;
         color_img[i] = '0;
      end
      rng_low = 0;
      rng_high = 0;
      rng_seen = 0;
      rows_reg = 128;
      cols_reg = 128;
      radius_reg = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_frames();
      test_backpressure();
      test_no_idle();
      wait_results();
      repeat (IDLE_WAIT) @(posedge clock);
      if (errors == 0 && pixel_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> sphere_splat_zbuffer_renderer.f
src/ssz_pkg.sv
src/ssz_ram.sv
src/ssz_shade_tab.sv
src/ssz_raster.sv
src/sphere_splat_zbuffer_renderer.sv
bench/tb_top.sv
